[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL of the 2x2 box downsampler.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, checked on the rising clock edge, off while reset is low.
`define RBD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Concurrent assertion, checked on every rising clock edge, reset included.
`define RBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/rbd_pkg.sv]
// ----------------------------------------------------------------------------
// rbd_pkg
// Widths, defaults and register indexes of the 2x2 RGB box downsampler.
// ----------------------------------------------------------------------------
package rbd_pkg;

    // Default frame limits, used as parameter defaults on the top level.
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Pixel format: three 8-bit channels, 9-bit horizontal pair sums.
    localparam int CHANNELS = 3;
    localparam int SAMPLE_W = 8;
    localparam int PAIR_W   = SAMPLE_W + 1;
    localparam int BOX_W    = SAMPLE_W + 2;
    localparam int PIX_W    = CHANNELS * SAMPLE_W;
    localparam int LINE_W   = CHANNELS * PAIR_W;

    // Configuration port.
    localparam int DIM_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int DIM_RESET = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

endpackage

[hdl/rgb_box_downsample_by_two.sv]
// ----------------------------------------------------------------------------
// rgb_box_downsample_by_two
// 2x2 box-filter downsampler for a raster stream of RGB pixels.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter in raster order on the pix channel (valid/ready), one word per
// pixel. For every aligned 2x2 block the block sends one word on the avg
// channel holding floor(sum / 4) per color; samples outside an odd-sized
// image count as zero. o_frame_last marks the final word of the reduced frame.
// Image width and height are set through the write port; the user must write
// them only while the block is idle, which the block itself does not enforce.
// A write restarts the frame at its first pixel. Throughput is one pixel per
// cycle while the receiver keeps up. Even-row pair sums sit in a line store
// with one write and one registered read port; the odd row reads them back.
// Accepting the pixel that completes a block loads the line store read and
// the stage register; the output register loads when the stage moves on.
// When the receiver stalls, the output register and one stage behind it
// fill, and then o_pix_ready drops; nothing is lost or repeated.
// Reset (synchronous, active low) sets width and height to 4096, clears the
// position counters and empties the pipeline. The line store is not cleared:
// every entry is written on an even row before the row below reads it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_box_downsample_by_two
    import rbd_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,

    // Input pixel channel.
    input  logic                 i_pix_valid,
    output logic                 o_pix_ready,
    input  logic [SAMPLE_W-1:0]  i_pix_red,
    input  logic [SAMPLE_W-1:0]  i_pix_green,
    input  logic [SAMPLE_W-1:0]  i_pix_blue,

    // Output pixel channel.
    output logic                 o_avg_valid,
    input  logic                 i_avg_ready,
    output logic [SAMPLE_W-1:0]  o_avg_red,
    output logic [SAMPLE_W-1:0]  o_avg_green,
    output logic [SAMPLE_W-1:0]  o_avg_blue,
    output logic                 o_frame_last
);

    localparam int CNT_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    localparam logic [CNT_W-1:0] WIDTH_M1_RST =
        CNT_W'(((DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET) - 1);
    localparam logic [ROW_W-1:0] HEIGHT_M1_RST =
        ROW_W'(((DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET) - 1);

    // Clamp a written dimension to 1..max and return it minus one.
    function automatic int clamp_m1(input logic [DIM_W-1:0] v, input int maxv);
        int val;
        val = int'(v);
        if (val < 1) begin
            return 0;
        end else if (val > maxv) begin
            return maxv - 1;
        end
        return val - 1;
    endfunction

    // Configuration and position state.
    logic [CNT_W-1:0]  r_width_m1;
    logic [ROW_W-1:0]  r_height_m1;
    logic [CNT_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [PIX_W-1:0]  r_left;

    // Line store of even-row pair sums.
    logic [LINE_W-1:0] r_line_mem [LINE_DEPTH];
    logic [LINE_W-1:0] r_line_rd;

    // Stage between acceptance and the output register.
    logic              r_s1_valid;
    logic [LINE_W-1:0] r_s1_pair;
    logic              r_s1_use_line;
    logic              r_s1_last;

    // Output register.
    logic                r_o_valid;
    logic [SAMPLE_W-1:0] r_o_red;
    logic [SAMPLE_W-1:0] r_o_green;
    logic [SAMPLE_W-1:0] r_o_blue;
    logic                r_o_last;

    logic              cfg_restart;
    logic              pix_accept;
    logic              s1_move;
    logic              col_odd;
    logic              row_odd;
    logic              last_col;
    logic              last_row;
    logic              col_done;
    logic              line_we;
    logic              line_re;
    logic              emit;
    logic [ADDR_W-1:0] line_addr;
    logic [PIX_W-1:0]  pix_word;
    logic [LINE_W-1:0] pair_word;
    logic [CNT_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    logic [BOX_W-1:0]  box_sum [CHANNELS];

    // Handshake: the stage advances when the output register is free or drains.
    assign s1_move     = r_s1_valid && (!r_o_valid || i_avg_ready);
    assign o_pix_ready = !r_s1_valid || s1_move;
    assign pix_accept  = i_pix_valid && o_pix_ready;
    assign cfg_restart = i_cfg_we &&
                         (i_cfg_index == REG_IMAGE_WIDTH || i_cfg_index == REG_IMAGE_HEIGHT);

    // Position decode for the pixel on the input.
    assign col_odd   = r_col[0];
    assign row_odd   = r_row[0];
    assign last_col  = (r_col == r_width_m1);
    assign last_row  = (r_row == r_height_m1);
    assign col_done  = col_odd || last_col;
    assign line_addr = ADDR_W'(r_col >> 1);
    assign pix_word  = {i_pix_blue, i_pix_green, i_pix_red};

    // An even row that is not the last stores pair sums; the others emit.
    assign line_we = pix_accept && col_done && !row_odd && !last_row;
    assign line_re = pix_accept && col_done && row_odd;
    assign emit    = pix_accept && col_done && (row_odd || last_row);

    // Horizontal pair sums; a lone last column pairs with zero.
    always_comb begin
        for (int k = 0; k < CHANNELS; k++) begin
            if (col_odd) begin
                pair_word[k*PAIR_W +: PAIR_W] =
                    PAIR_W'(r_left[k*SAMPLE_W +: SAMPLE_W]) +
                    PAIR_W'(pix_word[k*SAMPLE_W +: SAMPLE_W]);
            end else begin
                pair_word[k*PAIR_W +: PAIR_W] = PAIR_W'(pix_word[k*SAMPLE_W +: SAMPLE_W]);
            end
        end
    end

    // Next raster position.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : ROW_W'(r_row + 1'b1);
        end else begin
            n_col = CNT_W'(r_col + 1'b1);
        end
    end

    // Configuration registers and the raster position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_m1  <= WIDTH_M1_RST;
            r_height_m1 <= HEIGHT_M1_RST;
            r_col       <= '0;
            r_row       <= '0;
            r_left      <= '0;
        end else if (cfg_restart) begin
            if (i_cfg_index == REG_IMAGE_WIDTH) begin
                r_width_m1 <= CNT_W'(clamp_m1(i_cfg_data, MAX_WIDTH));
            end else begin
                r_height_m1 <= ROW_W'(clamp_m1(i_cfg_data, MAX_HEIGHT));
            end
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
        end else if (pix_accept) begin
            r_col <= n_col;
            r_row <= n_row;
            if (!col_odd) begin
                r_left <= pix_word;
            end
        end
    end

    // Line store: one write port, one registered read port. A read and a
    // write of the same entry never fall on the same edge, since writes come
    // from even rows and reads from odd rows.
    always_ff @(posedge i_clk) begin
        if (line_we) begin
            r_line_mem[line_addr] <= pair_word;
        end
        if (line_re) begin
            r_line_rd <= r_line_mem[line_addr];
        end
    end

    // Stage register: pair sums of a completed block wait for the line data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (emit) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_s1_pair     <= pair_word;
            r_s1_use_line <= row_odd;
            r_s1_last     <= last_col && last_row;
        end
    end

    // Vertical sum of the two pair sums; the missing row below adds zero.
    always_comb begin
        for (int k = 0; k < CHANNELS; k++) begin
            box_sum[k] = BOX_W'(r_s1_pair[k*PAIR_W +: PAIR_W]) +
                         (r_s1_use_line ? BOX_W'(r_line_rd[k*PAIR_W +: PAIR_W]) : '0);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_move) begin
            r_o_valid <= 1'b1;
        end else if (i_avg_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_o_red   <= box_sum[0][BOX_W-1:2];
            r_o_green <= box_sum[1][BOX_W-1:2];
            r_o_blue  <= box_sum[2][BOX_W-1:2];
            r_o_last  <= r_s1_last;
        end
    end

    assign o_avg_valid  = r_o_valid;
    assign o_avg_red    = r_o_red;
    assign o_avg_green  = r_o_green;
    assign o_avg_blue   = r_o_blue;
    assign o_frame_last = r_o_last;

    // The input stalls only when both the stage and the output are held.
    `RBD_ASSERT(a_stall_cause, i_clk, i_rst_n,
        !o_pix_ready |-> (r_s1_valid && r_o_valid && !i_avg_ready),
        "input stalled without a full pipeline")

    // The raster position stays inside the configured frame.
    `RBD_ASSERT(a_pos_in_frame, i_clk, i_rst_n,
        (r_col <= r_width_m1) && (r_row <= r_height_m1),
        "raster position outside the frame")

    // The last pixel of a frame yields a result word flagged as last.
    `RBD_ASSERT(a_frame_end, i_clk, i_rst_n,
        (pix_accept && last_col && last_row && !cfg_restart) |=> (r_s1_valid && r_s1_last),
        "frame end did not produce a last result word")

endmodule

[tb/rgb_box_downsample_by_two_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_box_downsample_by_two_tb
// Self-checking bench for the 2x2 RGB box downsampler.
// A queue-fed driver streams pixels in raster order, and a scoreboard keeps
// the expected 2x2 averages from its own model of the block. A monitor checks
// each averaged word against the oldest expected one. Both sides stall at
// random. A short directed pass covers odd sizes, a 1x1 frame, writes to unused
// indexes and oversized width. Random phases follow, mostly with small frames
// and a few with wide or tall ones.
// ----------------------------------------------------------------------------
module rgb_box_downsample_by_two_tb;
    import rbd_pkg::*;

    localparam int LINE_DEPTH   = (MAX_WIDTH_DEF + 1) / 2;
    localparam int IDLE_PCT     = 18;
    localparam int RANDOM_ITEMS = 1750;
    localparam int DRAIN_TAIL   = 8;

    // Indexes that the block does not decode.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = CFG_IDX_W'(3);

    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
    } rgb_word_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
        logic                last;
    } avg_word_t;

    // Block ports.
    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [DIM_W-1:0]     i_cfg_data   = '0;
    logic                 i_pix_valid  = 1'b0;
    logic                 o_pix_ready;
    logic [SAMPLE_W-1:0]  i_pix_red    = '0;
    logic [SAMPLE_W-1:0]  i_pix_green  = '0;
    logic [SAMPLE_W-1:0]  i_pix_blue   = '0;
    logic                 o_avg_valid;
    logic                 i_avg_ready  = 1'b0;
    logic [SAMPLE_W-1:0]  o_avg_red;
    logic [SAMPLE_W-1:0]  o_avg_green;
    logic [SAMPLE_W-1:0]  o_avg_blue;
    logic                 o_frame_last;

    // Stimulus and scoreboard.
    rgb_word_t   pixels_to_send [$];
    avg_word_t   averages_due [$];
    bit          no_gaps = 1'b0;
    int unsigned sent_random = 0;
    int unsigned fail_count = 0;

    // Model state: registers, line of pair sums, held pixel, raster position.
    logic [DIM_W-1:0]    width_reg  = DIM_W'(DIM_RESET);
    logic [DIM_W-1:0]    height_reg = DIM_W'(DIM_RESET);
    logic [PAIR_W-1:0]   pair_sums [LINE_DEPTH][CHANNELS];
    rgb_word_t           left_hold = '0;
    int unsigned         col_pos = 0;
    int unsigned         row_pos = 0;

    rgb_box_downsample_by_two dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_pix_valid  (i_pix_valid),
        .o_pix_ready  (o_pix_ready),
        .i_pix_red    (i_pix_red),
        .i_pix_green  (i_pix_green),
        .i_pix_blue   (i_pix_blue),
        .o_avg_valid  (o_avg_valid),
        .i_avg_ready  (i_avg_ready),
        .o_avg_red    (o_avg_red),
        .o_avg_green  (o_avg_green),
        .o_avg_blue   (o_avg_blue),
        .o_frame_last (o_frame_last)
    );

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Out-of-range sizes behave as the nearest legal one.
    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Work out the average, if any, that one accepted pixel completes.
    task automatic predict_box_average(input rgb_word_t px);
        int unsigned         w_eff, h_eff, idx, total;
        logic [SAMPLE_W-1:0] cur [CHANNELS];
        logic [SAMPLE_W-1:0] lft [CHANNELS];
        logic [PAIR_W-1:0]   pair [CHANNELS];
        logic [SAMPLE_W-1:0] avg [CHANNELS];
        bit                  last_col, last_row, odd_col, odd_row;
        avg_word_t           res;
        w_eff = clamp_dim(width_reg, MAX_WIDTH_DEF);
        h_eff = clamp_dim(height_reg, MAX_HEIGHT_DEF);
        cur[0] = px.red;
        cur[1] = px.green;
        cur[2] = px.blue;
        lft[0] = left_hold.red;
        lft[1] = left_hold.green;
        lft[2] = left_hold.blue;
        last_col = (col_pos == w_eff - 1);
        last_row = (row_pos == h_eff - 1);
        odd_col  = col_pos[0];
        odd_row  = row_pos[0];

        // A block closes on an odd column or on the last column of the row.
        if (odd_col || last_col) begin
            idx = col_pos >> 1;
            for (int k = 0; k < CHANNELS; k++) begin
                pair[k] = odd_col ? PAIR_W'(lft[k]) + PAIR_W'(cur[k]) : PAIR_W'(cur[k]);
            end
            if (!odd_row && !last_row) begin
                // Top half of the block: park the pair sums for the next row.
                for (int k = 0; k < CHANNELS; k++) begin
                    pair_sums[idx][k] = pair[k];
                end
            end else begin
                // Bottom half, or a lone last row with zeros below it.
                for (int k = 0; k < CHANNELS; k++) begin
                    total  = pair[k] + (odd_row ? pair_sums[idx][k] : 0);
                    avg[k] = SAMPLE_W'(total >> 2);
                end
                res.red   = avg[0];
                res.green = avg[1];
                res.blue  = avg[2];
                res.last  = last_col && last_row;
                averages_due.push_back(res);
            end
        end

        if (!odd_col) begin
            left_hold = px;
        end
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endtask

    // Pixel driver: a word stays on the bus until it is taken.
    always @(posedge i_clk) begin : pixel_driver
        rgb_word_t nxt;
        if (!i_rst_n) begin
            i_pix_valid <= 1'b0;
        end else begin
            if (i_pix_valid && o_pix_ready) begin
                predict_box_average({i_pix_red, i_pix_green, i_pix_blue});
            end
            if (!i_pix_valid || o_pix_ready) begin
                if (pixels_to_send.size() != 0
                        && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = pixels_to_send.pop_front();
                    i_pix_valid <= 1'b1;
                    i_pix_red   <= nxt.red;
                    i_pix_green <= nxt.green;
                    i_pix_blue  <= nxt.blue;
                end else begin
                    i_pix_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string field,
                                        input logic [SAMPLE_W-1:0] want,
                                        input logic [SAMPLE_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endfunction

    // Average monitor: compare each taken word with the oldest expected one.
    always @(posedge i_clk) begin : avg_monitor
        avg_word_t want;
        if (!i_rst_n) begin
            i_avg_ready <= 1'b0;
        end else begin
            if (o_avg_valid && i_avg_ready) begin
                if (averages_due.size() == 0) begin
                    $error("average word with none expected");
                    fail_count++;
                end else begin
                    want = averages_due.pop_front();
                    check_field("avg_red", want.red, o_avg_red);
                    check_field("avg_green", want.green, o_avg_green);
                    check_field("avg_blue", want.blue, o_avg_blue);
                    check_field("frame_last", SAMPLE_W'(want.last), SAMPLE_W'(o_frame_last));
                end
            end
            i_avg_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Register write; a size write restarts the frame in the model too.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == REG_IMAGE_WIDTH || idx == REG_IMAGE_HEIGHT) begin
            if (idx == REG_IMAGE_WIDTH) width_reg = val;
            else height_reg = val;
            col_pos   = 0;
            row_pos   = 0;
            left_hold = '0;
        end
    endtask

    // Wait until every word is sent and every average is back, then let the pipeline drain.
    task automatic settle();
        do @(posedge i_clk);
        while (pixels_to_send.size() != 0 || i_pix_valid || averages_due.size() != 0);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    function automatic void push_px(input logic [SAMPLE_W-1:0] r, g, b);
        rgb_word_t px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        pixels_to_send.push_back(px);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random_pixels(input int unsigned n);
        @(negedge i_clk);
        for (int unsigned k = 0; k < n; k++) begin
            push_px(pick_sample(), pick_sample(), pick_sample());
        end
        sent_random += n;
    endtask

    // One random phase: new size, whole frames, possibly followed by a partial one.
    task automatic run_random_phase(input int unsigned phase_no);
        int unsigned w_val, h_val, w_eff, h_eff, n_items, split, which;
        which = $urandom_range(3);
        if (phase_no % 6 == 3) begin
            // Wide or tall frame, only its first part is sent.
            which = 2;
            if ($urandom_range(1)) begin
                case ($urandom_range(3))
                    0:       w_val = 4096;
                    1:       w_val = 4095;
                    2:       w_val = 8191;
                    default: w_val = $urandom_range(4097, 8190);
                endcase
                h_val = $urandom_range(0, 8191);
            end else begin
                w_val = $urandom_range(0, 3);
                h_val = $urandom_range(0, 1) ? 4096 : $urandom_range(4097, 8191);
            end
            n_items = $urandom_range(30, 160);
        end else begin
            w_val   = $urandom_range(0, 12);
            h_val   = $urandom_range(0, 9);
            w_eff   = clamp_dim(DIM_W'(w_val), MAX_WIDTH_DEF);
            h_eff   = clamp_dim(DIM_W'(h_val), MAX_HEIGHT_DEF);
            n_items = w_eff * h_eff * $urandom_range(1, 3) + $urandom_range(0, w_eff * h_eff - 1);
        end

        if (which != 1) write_reg(REG_IMAGE_WIDTH, DIM_W'(w_val));
        if (which != 0) write_reg(REG_IMAGE_HEIGHT, DIM_W'(h_val));
        no_gaps = (sent_random >= 600 && sent_random < 950);

        // Sometimes pause mid-frame for a write that must not restart it.
        if (n_items > 1 && $urandom_range(3) == 0) begin
            split = $urandom_range(1, n_items - 1);
            send_random_pixels(split);
            settle();
            write_reg($urandom_range(1) ? REG_UNUSED_A : REG_UNUSED_B,
                      DIM_W'($urandom_range(0, 8191)));
            n_items -= split;
        end
        send_random_pixels(n_items);
        settle();
    endtask

    // Main sequence.
    initial begin : stimulus
        int unsigned phase_no;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Odd width and height: partial blocks on the right column and bottom row.
        write_reg(REG_IMAGE_WIDTH, DIM_W'(3));
        write_reg(REG_IMAGE_HEIGHT, DIM_W'(3));
        @(negedge i_clk);
        for (int unsigned k = 0; k < 9; k++) begin
            push_px('1, '0, SAMPLE_W'(k * 29 + 7));
        end
        settle();

        // Zero sizes act as 1x1: every word closes a frame.
        write_reg(REG_IMAGE_WIDTH, DIM_W'(0));
        write_reg(REG_IMAGE_HEIGHT, DIM_W'(0));
        @(negedge i_clk);
        push_px('1, '0, SAMPLE_W'(3));
        push_px(SAMPLE_W'(3), '1, SAMPLE_W'(128));
        settle();

        // 4x2 frame with writes to unused indexes between its two rows.
        write_reg(REG_IMAGE_WIDTH, DIM_W'(4));
        write_reg(REG_IMAGE_HEIGHT, DIM_W'(2));
        @(negedge i_clk);
        for (int unsigned k = 0; k < 4; k++) begin
            push_px(SAMPLE_W'(k * 64 + 63), SAMPLE_W'(255 - k), SAMPLE_W'(k));
        end
        settle();
        write_reg(REG_UNUSED_A, '1);
        write_reg(REG_UNUSED_B, '0);
        @(negedge i_clk);
        for (int unsigned k = 0; k < 4; k++) begin
            push_px('1, SAMPLE_W'(k * 85), SAMPLE_W'(170 - k));
        end
        settle();

        // Width above the maximum is clamped; a single last row.
        write_reg(REG_IMAGE_WIDTH, '1);
        write_reg(REG_IMAGE_HEIGHT, DIM_W'(1));
        @(negedge i_clk);
        for (int unsigned k = 0; k < 4; k++) begin
            push_px('1, '1, '1);
        end
        settle();

        phase_no = 0;
        while (sent_random < RANDOM_ITEMS) begin
            run_random_phase(phase_no);
            phase_no++;
        end

        if (fail_count == 0) begin
            $display("rgb_box_downsample_by_two_tb: clean");
        end else begin
            $display("rgb_box_downsample_by_two_tb: errors");
        end
        $finish;
    end

    // Watchdog.
    initial begin : watchdog
        #2000000;
        $display("rgb_box_downsample_by_two_tb: errors");
        $finish;
    end

endmodule

[rgb_box_downsample_by_two.f]
+incdir+hdl
hdl/rbd_pkg.sv
hdl/rgb_box_downsample_by_two.sv
tb/rgb_box_downsample_by_two_tb.sv
